FILE: hdl/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg
// Shared widths and register indexes for the shifted-force Coulomb pair block.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    localparam int unsigned DW      = 32;  // distance / divisor width, Q8.24
    localparam int unsigned QW      = 81;  // quotient width of 2^80 / D
    localparam int unsigned LIN_W   = 56;  // r/rc^2 term, Q.32
    localparam int unsigned INV_W   = 57;  // 1/r term, Q.32
    localparam int unsigned RES_W   = 48;  // result width, Q16.32
    localparam int unsigned CIDX_W  = 2;

    typedef enum logic [CIDX_W-1:0] {
        CFG_COUPLING   = 2'd0,
        CFG_INV_CUTOFF = 2'd1,
        CFG_MIN_RADIUS = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

endpackage

FILE: hdl/shifted_force_coulomb_pair.sv
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, two rows of 81 divider cells and 4 back stages.
// Throughput: one distance per cycle; the two rows of restoring-division
// cells each retire one quotient bit per cell per cycle.
// The whole pipeline stalls only while a result waits in the output register
// and the receiver is not taking it.
// Reset (synchronous, active low) clears valid bits and loads coupling 1.0,
// inv_cutoff 0.25 and min_radius 0.25.
// ----------------------------------------------------------------------------
// shifted_force_coulomb_pair
// Shifted-force Coulomb energy and force for one pair distance.
// ----------------------------------------------------------------------------
module shifted_force_coulomb_pair
    import sfcp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [DW-1:0]           i_distance,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [RES_W-1:0] o_pair_energy,
    output logic signed [RES_W-1:0] o_pair_force,
    output logic                    o_clamped,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CIDX_W-1:0]       i_cfg_index,
    input  logic [DW-1:0]           i_cfg_data
);

    localparam int unsigned S1_W = LIN_W + 1;
    localparam int unsigned S2_W = INV_W + LIN_W + 1;
    localparam int unsigned EM_W = INV_W + 1;     // energy magnitude
    localparam int unsigned LIM  = RES_W - 1;

    logic [DW-1:0]   r_cfg_coupling, r_cfg_inv_cutoff, r_cfg_min_radius;
    logic [2*DW-1:0] r_uu;
    logic            w_en;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_coupling   <= 32'd16777216;
            r_cfg_inv_cutoff <= 32'd4194304;
            r_cfg_min_radius <= 32'd4194304;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COUPLING:   r_cfg_coupling   <= i_cfg_data;
                CFG_INV_CUTOFF: r_cfg_inv_cutoff <= i_cfg_data;
                CFG_MIN_RADIUS: r_cfg_min_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // exact 1/rc^2; user holds config static for items in flight, unchecked
    always_ff @(posedge i_clk) begin
        r_uu <= r_cfg_inv_cutoff * r_cfg_inv_cutoff;
    end

    // ---- front: clamp, then r/rc^2 -------------------------------------
    logic [DW-1:0] w_m;
    logic          w_clamp;
    logic          r0_vld, r1_vld, r2_vld;
    logic [DW-1:0] r0_d, r1_d, r2_d;
    logic          r0_clamp, r1_clamp, r2_clamp;
    logic [2*DW-1:0] r1_plo, r1_phi;
    logic [LIN_W-1:0] r2_lin;
    logic [3*DW-1:0]  w_psum;

    assign w_m     = (r_cfg_min_radius == '0) ? DW'(1) : r_cfg_min_radius;
    assign w_clamp = (i_distance <= w_m);
    assign w_psum  = {r1_phi, {DW{1'b0}}} + {{DW{1'b0}}, r1_plo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= i_in_valid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_d     <= w_clamp ? w_m : i_distance;
            r0_clamp <= w_clamp;
            r1_plo   <= r_uu[DW-1:0] * r0_d;
            r1_phi   <= r_uu[2*DW-1:DW] * r0_d;
            r1_d     <= r0_d;
            r1_clamp <= r0_clamp;
            r2_lin   <= w_psum[3*DW-1:40];
            r2_d     <= r1_d;
            r2_clamp <= r1_clamp;
        end
    end

    // ---- 2^80 / D, then (2^80 / D) / D ----------------------------------
    logic            w_d1_vld, w_d2_vld;
    logic [QW-1:0]   w_q1, w_q2;
    logic [DW-1:0]   w_d1_div, w_d2_div;
    logic [S1_W-1:0] w_d1_side;
    logic [S2_W-1:0] w_d2_side;

    sfcp_div_chain #(.SIDE_W(S1_W)) u_div_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r2_vld),
        .i_num   ({1'b1, {(QW-1){1'b0}}}),
        .i_div   (r2_d),
        .i_side  ({r2_lin, r2_clamp}),
        .o_vld   (w_d1_vld),
        .o_quo   (w_q1),
        .o_div   (w_d1_div),
        .o_side  (w_d1_side)
    );

    sfcp_div_chain #(.SIDE_W(S2_W)) u_div_recip2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d1_vld),
        .i_num   (w_q1),
        .i_div   (w_d1_div),
        .i_side  ({w_q1[QW-1:24], w_d1_side}),
        .o_vld   (w_d2_vld),
        .o_quo   (w_q2),
        .o_div   (w_d2_div),
        .o_side  (w_d2_side)
    );

    logic w_unused;
    assign w_unused = ^w_d2_div;

    // ---- back: signed sums, scale by coupling, saturate -----------------
    logic [INV_W-1:0] w_inv;
    logic [LIN_W-1:0] w_lin;
    logic [EM_W-1:0]  w_pos, w_twou;
    logic [QW-1:0]    w_usq;

    assign w_inv  = w_d2_side[S2_W-1 -: INV_W];
    assign w_lin  = w_d2_side[S1_W-1:1];
    assign w_pos  = EM_W'(w_inv) + EM_W'(w_lin);
    assign w_twou = EM_W'({r_cfg_inv_cutoff, 9'd0});
    assign w_usq  = QW'(r_uu[2*DW-1:16]);

    logic            r3_vld, r4_vld, r5_vld;
    logic            r3_clamp, r4_clamp, r5_clamp;
    logic            r3_eneg, r4_eneg, r5_eneg, r3_fneg, r4_fneg, r5_fneg;
    logic [EM_W-1:0] r3_em;
    logic [QW-1:0]   r3_fm;
    logic [2*DW-1:0] r4_ep0, r4_ep1, r4_fp0, r4_fp1, r4_fp2;
    logic [EM_W+DW-1:0] r5_ep;
    logic [QW+DW-1:0]   r5_fp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_d2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_clamp <= w_d2_side[0];
            r3_eneg  <= (w_pos < w_twou);
            r3_em    <= (w_pos < w_twou) ? (w_twou - w_pos) : (w_pos - w_twou);
            r3_fneg  <= (w_q2 < w_usq);
            r3_fm    <= (w_q2 < w_usq) ? (w_usq - w_q2) : (w_q2 - w_usq);

            r4_ep0   <= r3_em[DW-1:0] * r_cfg_coupling;
            r4_ep1   <= DW'(r3_em[EM_W-1:DW]) * r_cfg_coupling;
            r4_fp0   <= r3_fm[DW-1:0] * r_cfg_coupling;
            r4_fp1   <= r3_fm[2*DW-1:DW] * r_cfg_coupling;
            r4_fp2   <= DW'(r3_fm[QW-1:2*DW]) * r_cfg_coupling;
            r4_clamp <= r3_clamp;
            r4_eneg  <= r3_eneg;
            r4_fneg  <= r3_fneg;

            r5_ep    <= (EM_W+DW)'(r4_ep0) + ((EM_W+DW)'(r4_ep1) << DW);
            r5_fp    <= (QW+DW)'(r4_fp0) + ((QW+DW)'(r4_fp1) << DW)
                        + ((QW+DW)'(r4_fp2) << (2*DW));
            r5_clamp <= r4_clamp;
            r5_eneg  <= r4_eneg;
            r5_fneg  <= r4_fneg;
        end
    end

    // drop 24 fraction bits, clamp magnitude, apply sign
    logic [EM_W+DW-25:0] w_ev;
    logic [QW+DW-25:0]   w_fv;
    logic [RES_W:0]      w_elim, w_flim, w_emag, w_fmag;

    assign w_ev   = r5_ep[EM_W+DW-1:24];
    assign w_fv   = r5_fp[QW+DW-1:24];
    assign w_elim = r5_eneg ? (RES_W+1)'(1) << LIM : ((RES_W+1)'(1) << LIM) - 1'b1;
    assign w_flim = r5_fneg ? (RES_W+1)'(1) << LIM : ((RES_W+1)'(1) << LIM) - 1'b1;
    assign w_emag = (w_ev > (EM_W+DW-24)'(w_elim)) ? w_elim : w_ev[RES_W:0];
    assign w_fmag = (w_fv > (QW+DW-24)'(w_flim)) ? w_flim : w_fv[RES_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_pair_energy <= r5_eneg ? -w_emag[RES_W-1:0] : w_emag[RES_W-1:0];
            o_pair_force  <= r5_fneg ? -w_fmag[RES_W-1:0] : w_fmag[RES_W-1:0];
            o_clamped     <= r5_clamp;
        end
    end

endmodule

FILE: hdl/sfcp_div_cell.sv
// ----------------------------------------------------------------------------
// sfcp_div_cell
// One restoring-division step: shifts a numerator bit into the remainder,
// subtracts the divisor when possible and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module sfcp_div_cell
    import sfcp_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [QW-1:0]     i_num,
    input  logic [DW-1:0]     i_rem,
    input  logic [DW-1:0]     i_div,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [QW-1:0]     o_num,
    output logic [DW-1:0]     o_rem,
    output logic [DW-1:0]     o_div,
    output logic [SIDE_W-1:0] o_side
);

    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;

    assign w_trial = {i_rem, i_num[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, i_div});
    assign w_diff  = w_trial - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_num  <= {i_num[QW-2:0], w_ge};
            o_rem  <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            o_div  <= i_div;
            o_side <= i_side;
        end
    end

endmodule

FILE: hdl/sfcp_div_chain.sv
// ----------------------------------------------------------------------------
// sfcp_div_chain
// Row of QW division cells; the numerator word turns into the quotient as it
// moves down the row, one bit per cell.
// ----------------------------------------------------------------------------
module sfcp_div_chain
    import sfcp_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [QW-1:0]     i_num,
    input  logic [DW-1:0]     i_div,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [QW-1:0]     o_quo,
    output logic [DW-1:0]     o_div,
    output logic [SIDE_W-1:0] o_side
);

    logic              w_vld  [QW+1];
    logic [QW-1:0]     w_num  [QW+1];
    logic [DW-1:0]     w_rem  [QW+1];
    logic [DW-1:0]     w_div  [QW+1];
    logic [SIDE_W-1:0] w_side [QW+1];

    assign w_vld[0]  = i_vld;
    assign w_num[0]  = i_num;
    assign w_rem[0]  = '0;
    assign w_div[0]  = i_div;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        sfcp_div_cell #(.SIDE_W(SIDE_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_vld   (w_vld[g]),
            .i_num   (w_num[g]),
            .i_rem   (w_rem[g]),
            .i_div   (w_div[g]),
            .i_side  (w_side[g]),
            .o_vld   (w_vld[g+1]),
            .o_num   (w_num[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    // final remainder is not needed
    assign o_vld  = w_vld[QW];
    assign o_quo  = w_num[QW];
    assign o_div  = w_div[QW];
    assign o_side = w_side[QW];

    logic w_unused;
    assign w_unused = ^w_rem[QW];

endmodule

FILE: tb/sv/tb_shifted_force_coulomb_pair.sv
// ----------------------------------------------------------------------------
// Shifted-force Coulomb pair testbench
// Streams pair distances through the block under random valid/ready gaps,
// predicts energy, force and clamp flag per distance in a scoreboard class,
// and walks the three registers through default, extreme and random values.
// ----------------------------------------------------------------------------
module tb_shifted_force_coulomb_pair;
    import sfcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 169;
    localparam longint MAX_CYCLES = 2000000;

    // ------------------------------------------------------------------------
    class pair_scoreboard;
        logic [31:0] coupling_q, inv_cutoff_q, min_radius_q;
        logic [RES_W-1:0] energy_q[$];
        logic [RES_W-1:0] force_q[$];
        logic clamp_q[$];
        int unsigned errors, checked, clamped_seen, neg_energy_seen, sat_seen;

        function new();
            coupling_q = 32'd16777216;
            inv_cutoff_q = 32'd4194304;
            min_radius_q = 32'd4194304;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_COUPLING:   coupling_q = val;
                CFG_INV_CUTOFF: inv_cutoff_q = val;
                CFG_MIN_RADIUS: min_radius_q = val;
                default: ;
            endcase
        endfunction

        // sign-magnitude times coupling, truncated toward zero, then saturated
        function logic [RES_W-1:0] scale_saturate(logic neg, logic [81:0] mag);
            logic [113:0] prod;
            logic [89:0] shifted;
            logic [47:0] lim, v;
            prod = mag * coupling_q;
            shifted = 90'(prod >> 24);
            lim = neg ? 48'h800000000000 : 48'h7FFFFFFFFFFF;
            if (shifted > lim) begin
                v = lim;
                sat_seen++;
            end else begin
                v = shifted[47:0];
            end
            return neg ? -v : v;
        endfunction

        function void note_distance(logic [31:0] pair_dist);
            logic [31:0] m, d;
            logic [63:0] usq_full, twou, inv, lin, pos;
            logic [95:0] lin_full;
            logic [81:0] mag, inv2, usq;
            logic [63:0] d2;
            logic neg, clamp;
            m = (min_radius_q == 0) ? 32'd1 : min_radius_q;
            clamp = pair_dist <= m;
            d = clamp ? m : pair_dist;
            usq_full = inv_cutoff_q * inv_cutoff_q;
            inv = (64'd1 << 56) / d;
            twou = {32'd0, inv_cutoff_q} << 9;
            lin_full = usq_full * d;
            lin = 64'(lin_full >> 40);
            pos = inv + lin;
            neg = pos < twou;
            mag = neg ? 82'(twou - pos) : 82'(pos - twou);
            if (neg) neg_energy_seen++;
            energy_q.push_back(scale_saturate(neg, mag));
            d2 = d * d;
            inv2 = (82'd1 << 80) / d2;
            usq = 82'(usq_full >> 16);
            neg = inv2 < usq;
            mag = neg ? (usq - inv2) : (inv2 - usq);
            force_q.push_back(scale_saturate(neg, mag));
            clamp_q.push_back(clamp);
            if (clamp) clamped_seen++;
        endfunction

        function int pending();
            return energy_q.size();
        endfunction

        function void check_result(logic [RES_W-1:0] e, logic [RES_W-1:0] f, logic c);
            logic [RES_W-1:0] exp_e, exp_f;
            logic exp_c;
            if (energy_q.size() == 0) begin
                report_mismatch("result with no distance pending", 0, e);
                return;
            end
            exp_e = energy_q.pop_front();
            exp_f = force_q.pop_front();
            exp_c = clamp_q.pop_front();
            checked++;
            if (e !== exp_e) report_mismatch("pair_energy", exp_e, e);
            if (f !== exp_f) report_mismatch("pair_force", exp_f, f);
            if (c !== exp_c) report_mismatch("clamped", exp_c, c);
        endfunction

        function void report_mismatch(string what, logic [RES_W-1:0] exp_v,
                                      logic [RES_W-1:0] got_v);
            errors++;
            if (errors <= 40)
                $display("MISMATCH %s: expected %h got %h (result %0d)",
                         what, exp_v, got_v, checked);
        endfunction
    endclass
    // ------------------------------------------------------------------------

    logic i_clk, i_rst_n;
    logic i_in_valid, o_in_ready;
    logic [DW-1:0] i_distance;
    logic o_out_valid, i_out_ready;
    logic signed [RES_W-1:0] o_pair_energy, o_pair_force;
    logic o_clamped;
    logic i_cfg_valid, o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [DW-1:0] i_cfg_data;

    shifted_force_coulomb_pair dut (.*);

    pair_scoreboard sb = new();
    longint cycle_count = 0;
    bit quiet_tail = 0;
    bit hold_sink = 0;
    bit stim_done = 0;
    int unsigned sent = 0;

    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, long hold-off on request
    initial begin
        int gap;
        i_out_ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_sink) begin
                i_out_ready <= 0;
                @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 13);
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_out_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_pair_energy, o_pair_force, o_clamped);
    end

    task automatic send_distance(logic [31:0] pair_dist);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_distance <= pair_dist;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_distance(pair_dist);
        sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_in_valid <= 0;
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_distance();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0100_0000);
            2: return sb.min_radius_q + $urandom_range(0, 3) - 2;
            3: return 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: return $urandom_range(32'h0040_0000, 32'h0800_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_reg();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(32'h0004_0000, 32'h0400_0000);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        i_rst_n = 0;
        i_in_valid = 0;
        i_distance = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_COUPLING;
        i_cfg_data = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: default registers
        directed = '{32'd0, 32'd1, 32'h0040_0000, 32'h0040_0001, 32'h0100_0000,
                     32'h0400_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555,
                     32'hAAAA_AAAA};
        foreach (directed[i]) send_distance(directed[i]);
        drain();
        // zero minimum radius, distance 0 and 1 land on D = 1
        write_reg(CFG_MIN_RADIUS, 32'd0);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        foreach (directed[i]) send_distance(directed[i]);
        drain();
        write_reg(CFG_COUPLING, 32'd0);
        write_reg(CFG_INV_CUTOFF, 32'hFFFF_FFFF);
        send_distance(32'd2);
        send_distance(32'hFFFF_FFFF);
        drain();
        write_reg(CFG_COUPLING, 32'hFFFF_FFFF);
        write_reg(CFG_MIN_RADIUS, 32'hFFFF_FFFF);
        send_distance(32'd0);
        send_distance(32'hFFFF_FFFF);
        drain();

        // random phases with fresh register settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_COUPLING, rand_reg());
            write_reg(CFG_INV_CUTOFF, rand_reg());
            write_reg(CFG_MIN_RADIUS, rand_reg());
            if (ph == 3) begin
                fork
                    begin
                        hold_sink = 1;
                        repeat (400) @(posedge i_clk);
                        hold_sink = 0;
                    end
                join_none
            end
            if (ph == 8) quiet_tail = 1;
            repeat (125) send_distance(rand_distance());
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        $display("Checked %0d results from %0d distances: %0d clamped, %0d negative energy,",
                 sb.checked, sent, sb.clamped_seen, sb.neg_energy_seen);
        $display("%0d saturated terms, across default, extreme and random registers",
                 sb.sat_seen);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/sfcp_pkg.sv
hdl/sfcp_div_cell.sv
hdl/sfcp_div_chain.sv
hdl/shifted_force_coulomb_pair.sv
tb/sv/tb_shifted_force_coulomb_pair.sv
